/* hw/rtl/dlwu_pkg.sv */
// ----------------------------------------------------------------------------
// Dirty line window updater package
// Shared codes, register indexes, reset values and widths for the updater.
// ----------------------------------------------------------------------------
package dlwu_pkg;

   localparam int MAX_LINES  = 1024;
   localparam int PAGE_BYTES = 4096;

   localparam int LOW_W      = $clog2(MAX_LINES);
   localparam int LINE_W     = 11;
   localparam int COL_W      = 11;
   localparam int BPL_W      = 13;
   localparam int SHIFT_W    = 10;
   localparam int PAGE_W     = 10;
   localparam int OFFSET_W   = 22;
   localparam int LENGTH_W   = 23;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int SLOT_W     = 4;

   localparam logic [LOW_W-1:0]  LOW_MAX  = LOW_W'(MAX_LINES - 1);
   localparam logic [LINE_W-1:0] HIGH_MAX = {LINE_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LINE_MARK = 2'd0,
      OP_PAGE_MARK = 2'd1,
      OP_FLUSH     = 2'd2,
      OP_NONE      = 2'd3
   } opcode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LINES    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLUMNS  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_LINE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_SHIFT   = CSR_IDX_W'(3);

   localparam logic [LINE_W-1:0]  RST_FRAME_LINES    = LINE_W'(240);
   localparam logic [COL_W-1:0]   RST_FRAME_COLUMNS  = COL_W'(240);
   localparam logic [BPL_W-1:0]   RST_BYTES_PER_LINE = BPL_W'(480);
   localparam logic [SHIFT_W-1:0] RST_COLUMN_SHIFT   = SHIFT_W'(80);

   localparam logic [7:0] CMD_COLUMN = 8'h2A;
   localparam logic [7:0] CMD_PAGE   = 8'h2B;
   localparam logic [7:0] CMD_WRITE  = 8'h2C;

   localparam logic [SLOT_W-1:0] SLOT_COL_CMD   = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_COL_SH    = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_COL_SL    = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_COL_EH    = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] SLOT_COL_EL    = SLOT_W'(4);
   localparam logic [SLOT_W-1:0] SLOT_PAGE_CMD  = SLOT_W'(5);
   localparam logic [SLOT_W-1:0] SLOT_PAGE_SH   = SLOT_W'(6);
   localparam logic [SLOT_W-1:0] SLOT_PAGE_SL   = SLOT_W'(7);
   localparam logic [SLOT_W-1:0] SLOT_PAGE_EH   = SLOT_W'(8);
   localparam logic [SLOT_W-1:0] SLOT_PAGE_EL   = SLOT_W'(9);
   localparam logic [SLOT_W-1:0] SLOT_WRITE_CMD = SLOT_W'(10);
   localparam logic [SLOT_W-1:0] SLOT_DESC      = SLOT_W'(11);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_DIV_LO  = 6'b000010,
      ST_DIV_HI  = 6'b000100,
      ST_MUL_OFF = 6'b001000,
      ST_MUL_LEN = 6'b010000,
      ST_EMIT    = 6'b100000
   } state_type;

endpackage

/* hw/rtl/dirty_line_window_updater_unit.sv */
// ----------------------------------------------------------------------------
// Dirty line window updater unit
// Keeps the dirty line window of a serial display panel and, on a flush,
// issues the window commands followed by a framebuffer fetch descriptor.
// Line marks widen the window directly. Page marks run two passes of the
// shared restoring divider, one bit a cycle. A flush computes the fetch offset,
// then the fetch length, before the first of its 12 results, then one result per
// cycle while the consumer is ready; one transaction is in progress at a time.
// Synchronous reset restores the register defaults and clears the window.
// ----------------------------------------------------------------------------
module dirty_line_window_updater_unit #(
   parameter int PAGE_BYTES = dlwu_pkg::PAGE_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic                              req_whole_frame,
   input  logic [dlwu_pkg::LOW_W-1:0]        req_first_line,
   input  logic [dlwu_pkg::LINE_W-1:0]       req_line_count,
   input  logic [dlwu_pkg::PAGE_W-1:0]       req_page_number,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_kind,
   output logic [7:0]                        rsp_panel_byte,
   output logic                              rsp_data_flag,
   output logic [dlwu_pkg::OFFSET_W-1:0]     rsp_fetch_offset,
   output logic [dlwu_pkg::LENGTH_W-1:0]     rsp_fetch_length,
   output logic                              rsp_last,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dlwu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dlwu_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int LOW_W   = dlwu_pkg::LOW_W;
   localparam int LINE_W  = dlwu_pkg::LINE_W;
   localparam int BPL_W   = dlwu_pkg::BPL_W;
   localparam int DQ_W    = $clog2(dlwu_pkg::MAX_LINES * PAGE_BYTES);
   localparam int CNT_W   = $clog2(DQ_W + 1);
   localparam int REM_W   = BPL_W;
   localparam int PROD_W  = LINE_W + BPL_W;

   localparam logic [DQ_W-1:0] PB_V  = DQ_W'(PAGE_BYTES);
   localparam logic [DQ_W-1:0] PB_M1 = DQ_W'(PAGE_BYTES - 1);

   dlwu_pkg::state_type state_ff, state_in;

   logic [LINE_W-1:0]            fl_ff, fl_in;
   logic [dlwu_pkg::COL_W-1:0]   fc_ff, fc_in;
   logic [BPL_W-1:0]             bpl_ff, bpl_in;
   logic [dlwu_pkg::SHIFT_W-1:0] cs_ff, cs_in;
   logic [LOW_W-1:0]             low_ff, low_in;
   logic [LINE_W-1:0]            high_ff, high_in;

   logic [DQ_W-1:0]              dq_ff, dq_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [DQ_W-1:0]              base_ff, base_in;
   logic [LOW_W-1:0]             lo_ff, lo_in;
   logic [LOW_W-1:0]             s_ff, s_in;
   logic [LINE_W-1:0]            e_ff, e_in;
   logic [dlwu_pkg::OFFSET_W-1:0] off_ff, off_in;
   logic [dlwu_pkg::LENGTH_W-1:0] len_ff, len_in;
   logic [dlwu_pkg::SLOT_W-1:0]  slot_ff, slot_in;

   logic [LINE_W-1:0]            last_line;
   logic [dlwu_pkg::COL_W-1:0]   col_end;
   logic [LINE_W:0]              xe;
   logic [LINE_W:0]              line_end;
   logic [DQ_W-1:0]              page_base;
   logic                         window_bad;

   logic [REM_W:0]               rem_sh;
   logic [REM_W+1:0]             diff_w;
   logic                         borrow;
   logic [DQ_W-1:0]              quot;
   logic                         div_last;

   logic [LINE_W-1:0]            mul_a;
   logic [PROD_W-1:0]            product;

   logic                         wid_en;
   logic [LOW_W-1:0]             wid_lo;
   logic [LINE_W:0]              wid_hi;
   logic [LINE_W-1:0]            wid_hi_sat;

   assign last_line = (fl_ff == '0) ? '0 : fl_ff - LINE_W'(1);
   assign col_end   = (fc_ff == '0) ? '0 : fc_ff - dlwu_pkg::COL_W'(1);
   assign xe        = (LINE_W + 1)'(col_end) + (LINE_W + 1)'(cs_ff);
   assign line_end  = (LINE_W + 1)'(req_first_line) + (LINE_W + 1)'(req_line_count)
                      - (LINE_W + 1)'(1);
   assign page_base = DQ_W'(req_page_number) * PB_V;
   assign window_bad = (LINE_W'(low_ff) > high_ff) || (LINE_W'(low_ff) > last_line)
                       || (high_ff > last_line);

   assign rem_sh   = {rem_ff, dq_ff[DQ_W-1]};
   assign diff_w   = {1'b0, rem_sh} - (REM_W + 2)'(bpl_ff);
   assign borrow   = diff_w[REM_W+1];
   assign quot     = {dq_ff[DQ_W-2:0], ~borrow};
   assign div_last = (cnt_ff == CNT_W'(DQ_W - 1));

   assign mul_a   = (state_ff == dlwu_pkg::ST_MUL_OFF) ? LINE_W'(s_ff)
                    : e_ff - LINE_W'(s_ff) + LINE_W'(1);
   assign product = PROD_W'(mul_a) * PROD_W'(bpl_ff);

   assign req_ready = (state_ff == dlwu_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      fl_in    = fl_ff;
      fc_in    = fc_ff;
      bpl_in   = bpl_ff;
      cs_in    = cs_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      base_in  = base_ff;
      lo_in    = lo_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      off_in   = off_ff;
      len_in   = len_ff;
      slot_in  = slot_ff;
      wid_en   = 1'b0;
      wid_lo   = '0;
      wid_hi   = '0;

      if (csr_valid) begin
         case (csr_index)
            dlwu_pkg::CSR_FRAME_LINES:    fl_in  = csr_wdata[LINE_W-1:0];
            dlwu_pkg::CSR_FRAME_COLUMNS:  fc_in  = csr_wdata[dlwu_pkg::COL_W-1:0];
            dlwu_pkg::CSR_BYTES_PER_LINE: bpl_in = csr_wdata[BPL_W-1:0];
            dlwu_pkg::CSR_COLUMN_SHIFT:   cs_in  = csr_wdata[dlwu_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         dlwu_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (dlwu_pkg::opcode_type'(req_opcode))
                  dlwu_pkg::OP_LINE_MARK: begin
                     if (req_whole_frame) begin
                        wid_en = 1'b1;
                        wid_lo = '0;
                        wid_hi = (LINE_W + 1)'(last_line);
                     end else if (req_line_count != '0) begin
                        wid_en = 1'b1;
                        wid_lo = req_first_line;
                        wid_hi = line_end;
                     end
                  end
                  dlwu_pkg::OP_PAGE_MARK: begin
                     if (bpl_ff != '0) begin
                        dq_in    = page_base;
                        base_in  = page_base;
                        rem_in   = '0;
                        cnt_in   = '0;
                        state_in = dlwu_pkg::ST_DIV_LO;
                     end
                  end
                  dlwu_pkg::OP_FLUSH: begin
                     s_in     = window_bad ? '0 : low_ff;
                     e_in     = window_bad ? last_line : high_ff;
                     low_in   = (last_line > LINE_W'(dlwu_pkg::LOW_MAX)) ? dlwu_pkg::LOW_MAX
                                : last_line[LOW_W-1:0];
                     high_in  = '0;
                     slot_in  = dlwu_pkg::SLOT_COL_CMD;
                     state_in = dlwu_pkg::ST_MUL_OFF;
                  end
                  default: ;
               endcase
            end
         end
         dlwu_pkg::ST_DIV_LO: begin
            rem_in = borrow ? rem_sh[REM_W-1:0] : diff_w[REM_W-1:0];
            dq_in  = quot;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               lo_in    = (quot > DQ_W'(dlwu_pkg::LOW_MAX)) ? dlwu_pkg::LOW_MAX
                          : quot[LOW_W-1:0];
               dq_in    = base_ff + PB_M1;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = dlwu_pkg::ST_DIV_HI;
            end
         end
         dlwu_pkg::ST_DIV_HI: begin
            rem_in = borrow ? rem_sh[REM_W-1:0] : diff_w[REM_W-1:0];
            dq_in  = quot;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               wid_en   = 1'b1;
               wid_lo   = lo_ff;
               wid_hi   = (quot > DQ_W'(last_line)) ? (LINE_W + 1)'(last_line)
                          : quot[LINE_W:0];
               state_in = dlwu_pkg::ST_IDLE;
            end
         end
         dlwu_pkg::ST_MUL_OFF: begin
            off_in   = product[dlwu_pkg::OFFSET_W-1:0];
            state_in = dlwu_pkg::ST_MUL_LEN;
         end
         dlwu_pkg::ST_MUL_LEN: begin
            len_in   = product[dlwu_pkg::LENGTH_W-1:0];
            state_in = dlwu_pkg::ST_EMIT;
         end
         dlwu_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               if (slot_ff == dlwu_pkg::SLOT_DESC) begin
                  state_in = dlwu_pkg::ST_IDLE;
               end else begin
                  slot_in = slot_ff + dlwu_pkg::SLOT_W'(1);
               end
            end
         end
         default: state_in = dlwu_pkg::ST_IDLE;
      endcase

      wid_hi_sat = (wid_hi > (LINE_W + 1)'(dlwu_pkg::HIGH_MAX)) ? dlwu_pkg::HIGH_MAX
                   : wid_hi[LINE_W-1:0];
      if (wid_en) begin
         if (wid_lo < low_ff) begin
            low_in = wid_lo;
         end
         if (wid_hi_sat > high_ff) begin
            high_in = wid_hi_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dlwu_pkg::ST_IDLE;
         fl_ff    <= dlwu_pkg::RST_FRAME_LINES;
         fc_ff    <= dlwu_pkg::RST_FRAME_COLUMNS;
         bpl_ff   <= dlwu_pkg::RST_BYTES_PER_LINE;
         cs_ff    <= dlwu_pkg::RST_COLUMN_SHIFT;
         low_ff   <= '0;
         high_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fl_ff    <= fl_in;
         fc_ff    <= fc_in;
         bpl_ff   <= bpl_in;
         cs_ff    <= cs_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      base_ff <= base_in;
      lo_ff   <= lo_in;
      s_ff    <= s_in;
      e_ff    <= e_in;
      off_ff  <= off_in;
      len_ff  <= len_in;
      slot_ff <= slot_in;
   end

   assign rsp_valid        = (state_ff == dlwu_pkg::ST_EMIT);
   assign rsp_kind         = (slot_ff == dlwu_pkg::SLOT_DESC);
   assign rsp_last         = (slot_ff == dlwu_pkg::SLOT_DESC);
   assign rsp_fetch_offset = rsp_kind ? off_ff : '0;
   assign rsp_fetch_length = rsp_kind ? len_ff : '0;

   always_comb begin
      rsp_data_flag  = 1'b1;
      rsp_panel_byte = '0;
      case (slot_ff)
         dlwu_pkg::SLOT_COL_CMD: begin
            rsp_panel_byte = dlwu_pkg::CMD_COLUMN;
            rsp_data_flag  = 1'b0;
         end
         dlwu_pkg::SLOT_COL_SH:    rsp_panel_byte = 8'(cs_ff >> 8);
         dlwu_pkg::SLOT_COL_SL:    rsp_panel_byte = cs_ff[7:0];
         dlwu_pkg::SLOT_COL_EH:    rsp_panel_byte = 8'(xe >> 8);
         dlwu_pkg::SLOT_COL_EL:    rsp_panel_byte = xe[7:0];
         dlwu_pkg::SLOT_PAGE_CMD: begin
            rsp_panel_byte = dlwu_pkg::CMD_PAGE;
            rsp_data_flag  = 1'b0;
         end
         dlwu_pkg::SLOT_PAGE_SH:   rsp_panel_byte = 8'(s_ff >> 8);
         dlwu_pkg::SLOT_PAGE_SL:   rsp_panel_byte = s_ff[7:0];
         dlwu_pkg::SLOT_PAGE_EH:   rsp_panel_byte = 8'(e_ff >> 8);
         dlwu_pkg::SLOT_PAGE_EL:   rsp_panel_byte = e_ff[7:0];
         dlwu_pkg::SLOT_WRITE_CMD: begin
            rsp_panel_byte = dlwu_pkg::CMD_WRITE;
            rsp_data_flag  = 1'b0;
         end
         default: ;
      endcase
   end

   // The block never offers a result while it can take a new transaction.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response channels active together");

   // A flush leaves the tracker with an empty upper bound.
   a_flush_clears_high: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == dlwu_pkg::OP_FLUSH)) |=> (high_ff == '0))
      else $error("flush did not reset the dirty window");

   // Once the descriptor has gone, the block is free for the next transaction.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("not ready after the closing descriptor");

   // The emitted window never starts after it ends.
   a_window_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (LINE_W'(s_ff) <= e_ff))
      else $error("flushed window is inverted");

endmodule

/* tb/sv/dirty_line_window_updater_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty line window updater unit testbench
// Drives line marks, page marks and flushes through the request channel while
// the panel geometry is reprogrammed between phases, and checks every panel
// byte and fetch descriptor against a predictor of the dirty line window.
// ----------------------------------------------------------------------------
module dirty_line_window_updater_unit_tb;

   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_ITEMS    = 46;

   localparam int LOW_W      = dlwu_pkg::LOW_W;
   localparam int LINE_W     = dlwu_pkg::LINE_W;
   localparam int COL_W      = dlwu_pkg::COL_W;
   localparam int BPL_W      = dlwu_pkg::BPL_W;
   localparam int SHIFT_W    = dlwu_pkg::SHIFT_W;
   localparam int PAGE_W     = dlwu_pkg::PAGE_W;
   localparam int OFFSET_W   = dlwu_pkg::OFFSET_W;
   localparam int LENGTH_W   = dlwu_pkg::LENGTH_W;
   localparam int CSR_IDX_W  = dlwu_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = dlwu_pkg::CSR_DATA_W;

   typedef struct {
      dlwu_pkg::opcode_type opcode;
      logic                 whole_frame;
      logic [LOW_W-1:0]     first_line;
      logic [LINE_W-1:0]    line_count;
      logic [PAGE_W-1:0]    page_number;
   } dirty_event_type;

   typedef struct {
      logic                kind;
      logic [7:0]          panel_byte;
      logic                data_flag;
      logic [OFFSET_W-1:0] fetch_offset;
      logic [LENGTH_W-1:0] fetch_length;
      logic                last;
   } panel_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_opcode = '0;
   logic                  req_whole_frame = 1'b0;
   logic [LOW_W-1:0]      req_first_line = '0;
   logic [LINE_W-1:0]     req_line_count = '0;
   logic [PAGE_W-1:0]     req_page_number = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_kind;
   logic [7:0]            rsp_panel_byte;
   logic                  rsp_data_flag;
   logic [OFFSET_W-1:0]   rsp_fetch_offset;
   logic [LENGTH_W-1:0]   rsp_fetch_length;
   logic                  rsp_last;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                  req_fire_ff = 1'b0;
   logic                  rsp_fire_ff = 1'b0;
   logic                  csr_fire_ff = 1'b0;

   dirty_event_type       dirty_events_pending[$];
   panel_word_type        window_stream_due[$];
   dirty_event_type       next_event;
   panel_word_type        due_word;

   logic [LINE_W-1:0]     frame_lines_cfg   = dlwu_pkg::RST_FRAME_LINES;
   logic [COL_W-1:0]      frame_columns_cfg = dlwu_pkg::RST_FRAME_COLUMNS;
   logic [BPL_W-1:0]      bytes_per_line_cfg = dlwu_pkg::RST_BYTES_PER_LINE;
   logic [SHIFT_W-1:0]    column_shift_cfg  = dlwu_pkg::RST_COLUMN_SHIFT;
   logic [LOW_W-1:0]      dirty_low  = '0;
   logic [LINE_W-1:0]     dirty_high = '0;

   int unsigned           items_queued = 0;
   int unsigned           items_taken = 0;
   int unsigned           idle_cycles = 0;
   int unsigned           error_count = 0;
   int unsigned           req_gap = 0;
   int unsigned           rsp_gap = 0;
   int unsigned           req_level = 2;
   int unsigned           rsp_level = 2;

   dirty_line_window_updater_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_whole_frame  (req_whole_frame),
      .req_first_line   (req_first_line),
      .req_line_count   (req_line_count),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_panel_byte   (rsp_panel_byte),
      .rsp_data_flag    (rsp_data_flag),
      .rsp_fetch_offset (rsp_fetch_offset),
      .rsp_fetch_length (rsp_fetch_length),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int unsigned draw_gap(int unsigned level);
      if (level == 0) begin
         return 0;
      end
      if (level == 1) begin
         return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic dirty_event_type make_event(dlwu_pkg::opcode_type op, logic whole,
                                                  int unsigned first, int unsigned count,
                                                  int unsigned page);
      dirty_event_type ev;
      ev.opcode      = op;
      ev.whole_frame = whole;
      ev.first_line  = LOW_W'(first);
      ev.line_count  = LINE_W'(count);
      ev.page_number = PAGE_W'(page);
      return ev;
   endfunction

   function automatic void push_event(dirty_event_type ev);
      dirty_events_pending.push_back(ev);
      items_queued++;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         dlwu_pkg::CSR_FRAME_LINES:    frame_lines_cfg    = data[LINE_W-1:0];
         dlwu_pkg::CSR_FRAME_COLUMNS:  frame_columns_cfg  = data[COL_W-1:0];
         dlwu_pkg::CSR_BYTES_PER_LINE: bytes_per_line_cfg = data[BPL_W-1:0];
         dlwu_pkg::CSR_COLUMN_SHIFT:   column_shift_cfg   = data[SHIFT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void widen_window(int unsigned lo, int unsigned hi);
      if (lo < dirty_low) begin
         dirty_low = LOW_W'(lo);
      end
      if (hi > dlwu_pkg::HIGH_MAX) begin
         hi = 32'(dlwu_pkg::HIGH_MAX);
      end
      if (hi > dirty_high) begin
         dirty_high = LINE_W'(hi);
      end
   endfunction

   function automatic void push_panel_byte(int unsigned value, logic flag);
      panel_word_type w;
      w.kind         = 1'b0;
      w.panel_byte   = 8'(value);
      w.data_flag    = flag;
      w.fetch_offset = '0;
      w.fetch_length = '0;
      w.last         = 1'b0;
      window_stream_due.push_back(w);
   endfunction

   function automatic void track_dirty_event(dirty_event_type ev);
      int unsigned     last_line, lo, hi, s, e, xs, xe;
      longint unsigned base;
      panel_word_type  desc;
      last_line = (frame_lines_cfg == '0) ? 0 : 32'(frame_lines_cfg) - 1;
      case (ev.opcode)
         dlwu_pkg::OP_LINE_MARK: begin
            if (ev.whole_frame) begin
               widen_window(0, last_line);
            end else if (ev.line_count != '0) begin
               widen_window(32'(ev.first_line),
                            32'(ev.first_line) + 32'(ev.line_count) - 1);
            end
         end
         dlwu_pkg::OP_PAGE_MARK: begin
            if (bytes_per_line_cfg != '0) begin
               base = 64'(ev.page_number) * 64'(dlwu_pkg::PAGE_BYTES);
               lo = 32'(base / 64'(bytes_per_line_cfg));
               hi = 32'((base + 64'(dlwu_pkg::PAGE_BYTES) - 64'd1) / 64'(bytes_per_line_cfg));
               if (hi > last_line) begin
                  hi = last_line;
               end
               if (lo > dlwu_pkg::LOW_MAX) begin
                  lo = 32'(dlwu_pkg::LOW_MAX);
               end
               widen_window(lo, hi);
            end
         end
         dlwu_pkg::OP_FLUSH: begin
            s = 32'(dirty_low);
            e = 32'(dirty_high);
            dirty_low  = (last_line > dlwu_pkg::LOW_MAX) ? dlwu_pkg::LOW_MAX
                         : LOW_W'(last_line);
            dirty_high = '0;
            if (s > e || s > last_line || e > last_line) begin
               s = 0;
               e = last_line;
            end
            xs = 32'(column_shift_cfg);
            xe = ((frame_columns_cfg == '0) ? 0 : 32'(frame_columns_cfg) - 1) + xs;
            push_panel_byte(32'(dlwu_pkg::CMD_COLUMN), 1'b0);
            push_panel_byte(xs >> 8, 1'b1);
            push_panel_byte(xs, 1'b1);
            push_panel_byte(xe >> 8, 1'b1);
            push_panel_byte(xe, 1'b1);
            push_panel_byte(32'(dlwu_pkg::CMD_PAGE), 1'b0);
            push_panel_byte(s >> 8, 1'b1);
            push_panel_byte(s, 1'b1);
            push_panel_byte(e >> 8, 1'b1);
            push_panel_byte(e, 1'b1);
            push_panel_byte(32'(dlwu_pkg::CMD_WRITE), 1'b0);
            desc.kind         = 1'b1;
            desc.panel_byte   = '0;
            desc.data_flag    = 1'b1;
            desc.fetch_offset = OFFSET_W'(64'(s) * 64'(bytes_per_line_cfg));
            desc.fetch_length = LENGTH_W'(64'(e - s + 1) * 64'(bytes_per_line_cfg));
            desc.last         = 1'b1;
            window_stream_due.push_back(desc);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_panel_word();
      if (window_stream_due.size() == 0) begin
         report_mismatch($sformatf("result transaction with nothing expected (byte %02h)",
                                   rsp_panel_byte));
      end else begin
         due_word = window_stream_due.pop_front();
         if (rsp_kind !== due_word.kind)
            report_mismatch($sformatf("kind %0b, expected %0b", rsp_kind, due_word.kind));
         if (rsp_panel_byte !== due_word.panel_byte)
            report_mismatch($sformatf("panel_byte %02h, expected %02h",
                                      rsp_panel_byte, due_word.panel_byte));
         if (rsp_data_flag !== due_word.data_flag)
            report_mismatch($sformatf("data_flag %0b, expected %0b",
                                      rsp_data_flag, due_word.data_flag));
         if (rsp_fetch_offset !== due_word.fetch_offset)
            report_mismatch($sformatf("fetch_offset %0h, expected %0h",
                                      rsp_fetch_offset, due_word.fetch_offset));
         if (rsp_fetch_length !== due_word.fetch_length)
            report_mismatch($sformatf("fetch_length %0h, expected %0h",
                                      rsp_fetch_length, due_word.fetch_length));
         if (rsp_last !== due_word.last)
            report_mismatch($sformatf("last %0b, expected %0b", rsp_last, due_word.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_fire_ff <= 1'b0;
         rsp_fire_ff <= 1'b0;
         csr_fire_ff <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_fire_ff <= req_valid && req_ready;
         rsp_fire_ff <= rsp_valid && rsp_ready;
         csr_fire_ff <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_wdata);
         end
         if (req_valid && req_ready) begin
            track_dirty_event(make_event(dlwu_pkg::opcode_type'(req_opcode), req_whole_frame,
                                         32'(req_first_line), 32'(req_line_count),
                                         32'(req_page_number)));
            items_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            check_panel_word();
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("dirty_line_window_updater_unit regression: fail");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_fire_ff) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (dirty_events_pending.size() != 0) begin
            next_event = dirty_events_pending.pop_front();
            req_opcode      <= next_event.opcode;
            req_whole_frame <= next_event.whole_frame;
            req_first_line  <= next_event.first_line;
            req_line_count  <= next_event.line_count;
            req_page_number <= next_event.page_number;
            req_valid       <= 1'b1;
            req_gap = draw_gap(req_level);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_fire_ff) begin
            rsp_gap = draw_gap(rsp_level);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic wait_quiet();
      do @(negedge clock);
      while (items_taken != items_queued || window_stream_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, int unsigned value);
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      csr_valid <= 1'b1;
      do @(negedge clock);
      while (!csr_fire_ff);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_panel(int unsigned lines, int unsigned columns, int unsigned bpl,
                                int unsigned shift);
      write_register(dlwu_pkg::CSR_FRAME_LINES, lines);
      write_register(dlwu_pkg::CSR_FRAME_COLUMNS, columns);
      write_register(dlwu_pkg::CSR_BYTES_PER_LINE, bpl);
      write_register(dlwu_pkg::CSR_COLUMN_SHIFT, shift);
   endtask

   task automatic load_random_sequences(int unsigned count);
      dirty_event_type ev;
      int unsigned     target, marks, sel, frame_cap;
      target = items_queued + count;
      frame_cap = (frame_lines_cfg > 1023) ? 1023 : 32'(frame_lines_cfg);
      @(posedge clock);
      while (items_queued < target) begin
         marks = $urandom_range(0, 4);
         repeat (marks) begin
            sel = $urandom_range(0, 19);
            ev.opcode = (sel < 9) ? dlwu_pkg::OP_LINE_MARK :
                        (sel < 18) ? dlwu_pkg::OP_PAGE_MARK :
                        (sel == 18) ? dlwu_pkg::OP_NONE : dlwu_pkg::OP_FLUSH;
            ev.whole_frame = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1) == 0) begin
               ev.first_line = LOW_W'($urandom_range(0, frame_cap));
               ev.line_count = LINE_W'($urandom_range(1, 8));
            end else begin
               ev.first_line = ($urandom_range(0, 7) == 0) ? dlwu_pkg::LOW_MAX
                               : LOW_W'($urandom_range(0, 1023));
               sel = $urandom_range(0, 5);
               ev.line_count = (sel == 0) ? LINE_W'(0) : (sel == 1) ? LINE_W'(1024)
                               : LINE_W'($urandom_range(0, 1024));
            end
            ev.page_number = ($urandom_range(0, 1) == 0) ? PAGE_W'($urandom_range(0, 63))
                             : PAGE_W'($urandom_range(0, 1023));
            push_event(ev);
         end
         if ($urandom_range(0, 9) != 0) begin
            push_event(make_event(dlwu_pkg::OP_FLUSH, 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 1023), $urandom_range(0, 1024),
                                  $urandom_range(0, 1023)));
         end
      end
   endtask

   initial begin
      int unsigned phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset geometry: 240 lines of 480 bytes.
      @(posedge clock);
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_LINE_MARK, 1'b0, 10, 5, 0));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_LINE_MARK, 1'b0, 50, 0, 0));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_LINE_MARK, 1'b1, 1023, 1024, 1023));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_LINE_MARK, 1'b0, 1023, 1024, 0));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_PAGE_MARK, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_PAGE_MARK, 1'b0, 0, 0, 1023));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_PAGE_MARK, 1'b0, 0, 0, 3));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_NONE, 1'b1, 1023, 1024, 1023));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b1, 1023, 1024, 1023));
      push_event(make_event(dlwu_pkg::OP_LINE_MARK, 1'b0, 0, 1, 0));
      push_event(make_event(dlwu_pkg::OP_LINE_MARK, 1'b0, 100, 1, 0));
      push_event(make_event(dlwu_pkg::OP_PAGE_MARK, 1'b0, 0, 0, 1));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      push_event(make_event(dlwu_pkg::OP_LINE_MARK, 1'b0, 239, 1, 0));
      push_event(make_event(dlwu_pkg::OP_FLUSH, 1'b0, 0, 0, 0));
      wait_quiet();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: program_panel(1024, 1024, 4096, 1023);
            1: program_panel(1, 1, 1, 0);
            2: program_panel(0, 0, 0, 0);
            3: program_panel(2047, 2047, 8191, 1023);
            4: program_panel(240, 240, 480, 80);
            default: program_panel(($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                                : $urandom_range(1, 1024),
                                   $urandom_range(1, 1024),
                                   ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                                : $urandom_range(1, 4096),
                                   $urandom_range(0, 1023));
         endcase
         req_level = phase % 3;
         rsp_level = $urandom_range(0, 2);
         load_random_sequences(PHASE_ITEMS);
         wait_quiet();
      end

      if (error_count == 0)
         $display("dirty_line_window_updater_unit regression: pass");
      else
         $display("dirty_line_window_updater_unit regression: fail");
      $finish;
   end

endmodule
